// ----- rtl/core/tksm_pkg.sv -----
// Shared constants and types for the timed key sequence matcher.
package tksm_pkg;

  localparam int COMBO_SLOTS    = 4;
  localparam int SLOT_LIMIT     = 4;
  localparam int MAX_COMBO_KEYS = 8;
  localparam int KEY_BYTES      = 8;
  localparam int KEY_W          = 8;
  localparam int TIME_W         = 32;
  localparam int LEN_W          = 4;
  localparam int MASK_W         = 4;
  localparam int RULE_W         = 36;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;
  localparam int FILL_W         = $clog2(MAX_COMBO_KEYS + 1);
  localparam int IDX_W          = (MAX_COMBO_KEYS > 1) ? $clog2(MAX_COMBO_KEYS) : 1;

  // Combo key codes, first key in byte 0
  typedef logic [KEY_BYTES-1:0][KEY_W-1:0] keys_t;

  // Combo rule: window above, length in the low nibble
  typedef struct packed {
    logic [TIME_W-1:0] window;
    logic [LEN_W-1:0]  len;
  } rule_t;

  // One key press
  typedef struct packed {
    logic [TIME_W-1:0] press_time;
    logic [KEY_W-1:0]  key_code;
  } press_t;

  // Classified press handed from front to back
  typedef struct packed {
    logic [COMBO_SLOTS-1:0]             key_ok;
    logic [COMBO_SLOTS-1:0][TIME_W-1:0] elapsed;
  } q_item_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- rtl/core/tksm_front.sv -----
// Front end: accepts presses, keeps the recent history and checks key sequences.
module tksm_front import tksm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  press_t    in_press,
  input  keys_t     combo_keys [COMBO_SLOTS],
  input  rule_t     combo_rule [COMBO_SLOTS],
  output logic      q_push,
  output q_item_t   q_item,
  input  q_status_t q_status
);

  logic [KEY_W-1:0]  hist_key_r  [MAX_COMBO_KEYS];
  logic [TIME_W-1:0] hist_time_r [MAX_COMBO_KEYS];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              pending_r, pending_nxt;
  logic              accept;

  // Hold off a new press only while the classified one cannot leave
  assign in_ready    = !(pending_r && q_status.full);
  assign accept      = in_valid && in_ready;
  assign q_push      = pending_r && !q_status.full;
  assign pending_nxt = accept || (pending_r && q_status.full);
  assign fill_nxt    = (accept && (fill_r != FILL_W'(MAX_COMBO_KEYS))) ?
                       fill_r + FILL_W'(1) : fill_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      fill_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Shift the history, newest press at entry 0
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = MAX_COMBO_KEYS - 1; k > 0; k--) begin
        hist_key_r[k]  <= hist_key_r[k-1];
        hist_time_r[k] <= hist_time_r[k-1];
      end
      hist_key_r[0]  <= in_press.key_code;
      hist_time_r[0] <= in_press.press_time;
    end
  end

  // Compare each combo against the newest entries and time its first press
  always_comb begin : classify
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] back;
    logic [LEN_W-1:0] first;
    logic             len_ok;
    logic             keys_eq;
    q_item = '0;
    for (int s = 0; s < COMBO_SLOTS; s++) begin
      len     = combo_rule[s].len;
      len_ok  = (len != '0) && (int'(len) <= MAX_COMBO_KEYS) && (int'(len) <= int'(fill_r));
      keys_eq = 1'b1;
      for (int i = 0; i < MAX_COMBO_KEYS; i++) begin
        back = len - LEN_W'(1) - LEN_W'(i);
        if ((i < int'(len)) && (hist_key_r[back[IDX_W-1:0]] != combo_keys[s][i])) begin
          keys_eq = 1'b0;
        end
      end
      first               = len - LEN_W'(1);
      q_item.key_ok[s]    = len_ok && keys_eq;
      q_item.elapsed[s]   = hist_time_r[0] - hist_time_r[first[IDX_W-1:0]];
    end
  end

endmodule

// ----- rtl/core/tksm_queue.sv -----
// Two-entry queue between the front and back ends.
module tksm_queue import tksm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   wr_item,
  input  logic      pop,
  output q_item_t   rd_item,
  output q_status_t status
);

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_item      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

// ----- rtl/core/tksm_back.sv -----
// Back end: applies the time windows and holds the result word.
module tksm_back import tksm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_status_t         q_status,
  input  q_item_t           q_item,
  output logic              q_pop,
  input  rule_t             combo_rule [COMBO_SLOTS],
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_mask
);

  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;

  // Take the next word once the result register is free or being drained
  assign q_pop         = !q_status.empty && (!out_valid_r || out_ready);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_ready);

  always_comb begin
    mask_nxt = '0;
    for (int s = 0; s < SLOT_LIMIT; s++) begin
      if (s < COMBO_SLOTS) begin
        mask_nxt[s] = q_item.key_ok[s] && (q_item.elapsed[s] <= combo_rule[s].window);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (q_pop) mask_r <= mask_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_mask  = mask_r;

endmodule

// ----- rtl/core/timed_key_sequence_matcher.sv -----
// Top level of the timed key sequence matcher: configuration registers and wiring.
//
// Usage:
//   in_*  stream : one key press per word, in_tdata = key_code, press_time.
//   out_* stream : one result word per press, out_tdata = match_mask.
//   cfg_*        : register writes, index 2*i is combo_keys_i, 2*i+1 combo_rule_i;
//                  cfg_ready is always high, write only while the block is idle.
// Timing:
//   A press accepted into the history is classified in the front stage, pushed
//   into the queue when it has room and then registered as the result word in
//   the back end. One press per cycle is sustained while out_tready stays high;
//   the front end's history register and the two-entry queue let presses keep
//   flowing while a result waits.
// Reset:
//   rst_n (synchronous, active low) empties the history, the queue and the
//   result register and clears every combo (all combos disabled).
// Stall:
//   While out_tready is low the result word holds; the queue and the front stage
//   absorb up to three more presses, after which in_tready drops until it drains.
module timed_key_sequence_matcher import tksm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream: key_code [7:0], press_time [39:8]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Output stream: match_mask [3:0], zero pad [7:4]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  keys_t             combo_keys_r [COMBO_SLOTS];
  rule_t             combo_rule_r [COMBO_SLOTS];
  press_t            in_press;
  q_item_t           q_wr_item, q_rd_item;
  q_status_t         q_status;
  logic              q_push, q_pop;
  logic [MASK_W-1:0] out_mask;

  assign cfg_ready = 1'b1;
  assign in_press  = press_t'(in_tdata);
  assign out_tdata = {{(OUT_DATA_W - MASK_W){1'b0}}, out_mask};

  // Register writes; odd index selects the rule, indexes past the slots drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < COMBO_SLOTS; s++) begin
        combo_keys_r[s] <= '0;
        combo_rule_r[s] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int s = 0; s < COMBO_SLOTS; s++) begin
        if (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(s)) begin
          if (cfg_index[0]) combo_rule_r[s] <= rule_t'(cfg_data[RULE_W-1:0]);
          else              combo_keys_r[s] <= keys_t'(cfg_data);
        end
      end
    end
  end

  tksm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_press   (in_press),
    .combo_keys (combo_keys_r),
    .combo_rule (combo_rule_r),
    .q_push     (q_push),
    .q_item     (q_wr_item),
    .q_status   (q_status)
  );

  tksm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .status  (q_status)
  );

  tksm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .combo_rule (combo_rule_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_mask   (out_mask)
  );

endmodule

// ----- sim/timed_key_sequence_matcher_tb.sv -----
// Self-checking testbench for the timed key sequence matcher: directed and random presses.
module timed_key_sequence_matcher_tb;
  import tksm_pkg::*;

  localparam int HIST_DEPTH   = 16;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_LONG    = 300;
  localparam int CYCLE_LIMIT  = 800000;

  // Register map of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEYS_0, REG_RULE_0, REG_KEYS_1, REG_RULE_1,
    REG_KEYS_2, REG_RULE_2, REG_KEYS_3, REG_RULE_3,
    REG_COUNT
  } cfg_reg_e;

  // How combo windows are chosen in a random phase
  typedef enum int {WIN_WIDE, WIN_TIGHT, WIN_MIXED} win_mode_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Shadow of the combo registers and the press history
  keys_t             combo_keys [COMBO_SLOTS];
  rule_t             combo_rule [COMBO_SLOTS];
  logic [KEY_W-1:0]  hist_key[$];
  logic [TIME_W-1:0] hist_time[$];

  // Masks still owed by the block, oldest first
  logic [MASK_W-1:0] pending_masks[$];
  logic [MASK_W-1:0] exp_mask;

  int  error_count  = 0;
  int  presses_sent = 0;
  int  matches_seen = 0;
  int  cfg_writes   = 0;
  int  cycle_count  = 0;
  int  hold_cycles  = 0;
  int  recv_idle    = 0;
  bit  no_idle      = 1'b0;

  timed_key_sequence_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // key_code [7:0], press_time [39:8]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // match_mask [3:0], zero pad [7:4]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Update the register shadow; unknown indices drop
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_KEYS_0: combo_keys[0] = data;
      REG_RULE_0: combo_rule[0] = data[RULE_W-1:0];
      REG_KEYS_1: combo_keys[1] = data;
      REG_RULE_1: combo_rule[1] = data[RULE_W-1:0];
      REG_KEYS_2: combo_keys[2] = data;
      REG_RULE_2: combo_rule[2] = data[RULE_W-1:0];
      REG_KEYS_3: combo_keys[3] = data;
      REG_RULE_3: combo_rule[3] = data[RULE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic cfg_reg_e keys_reg(input int slot);
    case (slot)
      0:       return REG_KEYS_0;
      1:       return REG_KEYS_1;
      2:       return REG_KEYS_2;
      default: return REG_KEYS_3;
    endcase
  endfunction

  function automatic cfg_reg_e rule_reg(input int slot);
    case (slot)
      0:       return REG_RULE_0;
      1:       return REG_RULE_1;
      2:       return REG_RULE_2;
      default: return REG_RULE_3;
    endcase
  endfunction

  // Push one press into the history and work out which combos it completes
  function automatic logic [MASK_W-1:0] predict_match(input logic [KEY_W-1:0] key,
                                                      input logic [TIME_W-1:0] now);
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] elapsed;
    int                len;
    int                first;
    bit                hit;
    mask = '0;
    if (hist_key.size() >= HIST_DEPTH) begin
      void'(hist_key.pop_front());
      void'(hist_time.pop_front());
    end
    hist_key  = {hist_key, key};
    hist_time = {hist_time, now};
    for (int s = 0; s < COMBO_SLOTS; s++) begin
      len = int'(combo_rule[s].len);
      // disabled, overlong or longer than the history: no match
      if (len == 0 || len > MAX_COMBO_KEYS || len > hist_key.size()) continue;
      first = hist_key.size() - len;
      hit = 1'b1;
      for (int i = 0; i < len; i++)
        if (hist_key[first + i] != combo_keys[s][i]) hit = 1'b0;
      elapsed = now - hist_time[first];
      if (hit && elapsed <= combo_rule[s].window) mask[s] = 1'b1;
    end
    return mask;
  endfunction

  // Offer one press word and record its expected mask once taken
  task automatic send_press(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp);
    int     gap;
    press_t word;
    gap = pick_gap();
    word.key_code   = key;
    word.press_time = stamp;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    pending_masks = {pending_masks, predict_match(key, stamp)};
    presses_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Load one combo; junk above the rule field must be dropped
  task automatic program_slot(input int slot, input keys_t keys, input logic [LEN_W-1:0] len,
                              input logic [TIME_W-1:0] window);
    logic [CFG_DATA_W-RULE_W-1:0] junk;
    junk = (CFG_DATA_W - RULE_W)'($urandom());
    write_reg(keys_reg(slot), keys);
    write_reg(rule_reg(slot), {junk, window, len});
  endtask

  // Stop offering and wait until every owed mask has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(MAX_COMBO_KEYS + 1, (1 << LEN_W) - 1));
    if (r < 4)  return LEN_W'(MAX_COMBO_KEYS);
    return LEN_W'($urandom_range(1, MAX_COMBO_KEYS));
  endfunction

  function automatic logic [TIME_W-1:0] pick_window(input win_mode_e mode);
    int r;
    r = $urandom_range(0, 9);
    case (mode)
      WIN_WIDE:  return '1;
      WIN_TIGHT: return $urandom_range(0, 3);
      default: begin
        if (r == 0) return '1;
        if (r == 1) return '0;
        return $urandom_range(0, 600);
      end
    endcase
  endfunction

  // Small forward steps, rarely a jump anywhere (backward wraps too)
  function automatic logic [TIME_W-1:0] next_step(input int step_max);
    if ($urandom_range(0, 49) == 0) return $urandom();
    return $urandom_range(0, step_max);
  endfunction

  // All combos disabled straight out of reset
  task automatic test_reset_state();
    send_press(8'h00, 32'h0);
  endtask

  // Zero-key combos must wait for the history to fill
  task automatic test_short_history();
    drain_results();
    program_slot(0, 64'h0, 4'd3, '1);
    program_slot(1, 64'h0, 4'd1, '0);
    program_slot(2, 64'h0, LEN_W'(MAX_COMBO_KEYS), '1);
    program_slot(3, '1, '0, '1);
    repeat (7) send_press(8'h00, 32'd5);
  endtask

  // Window exactly met across the wrap, missed by one, and a wrapped earlier press
  task automatic test_window_edges();
    drain_results();
    program_slot(0, 64'h55AA, 4'd2, 32'd10);
    program_slot(1, 64'h55AA, 4'd2, '1);
    program_slot(2, '1, LEN_W'(MAX_COMBO_KEYS + 1), '1);
    program_slot(3, 64'hAA, '1, '1);
    send_press(8'hAA, 32'hFFFF_FFFA);
    send_press(8'h55, 32'd4);
    send_press(8'hAA, 32'd100);
    send_press(8'h55, 32'd111);
    send_press(8'hAA, 32'd200);
    send_press(8'h55, 32'd150);
  endtask

  // Extreme key codes, a full-length combo and zero windows
  task automatic test_extreme_codes();
    drain_results();
    program_slot(0, '1, LEN_W'(MAX_COMBO_KEYS), 32'd7);
    program_slot(1, 64'h00FF, 4'd2, '0);
    program_slot(2, 64'h0, 4'd1, '0);
    program_slot(3, '1, '1, '1);
    for (int i = 0; i < MAX_COMBO_KEYS; i++) send_press(8'hFF, 32'hFFFF_FFFC + i);
    send_press(8'h00, 32'd3);
  endtask

  // Writes past the register map must change nothing
  task automatic test_bad_index();
    logic [CFG_IDX_W-1:0] bad_idx;
    drain_results();
    for (int i = REG_COUNT; i < (1 << CFG_IDX_W); i++) begin
      bad_idx = CFG_IDX_W'(i);
      write_reg(bad_idx, {$urandom(), $urandom()});
    end
    send_press(8'h00, 32'd3);
  endtask

  // Hold the receiver off for a long stretch while presses keep coming
  task automatic test_backpressure();
    drain_results();
    for (int s = 0; s < COMBO_SLOTS; s++)
      program_slot(s, {KEY_BYTES{8'h11}}, LEN_W'($urandom_range(1, 3)),
                   pick_window(WIN_MIXED));
    no_idle = 1'b1;
    @(posedge clk);
    hold_cycles = HOLD_LONG;
    for (int i = 0; i < 40; i++)
      send_press(($urandom_range(0, 3) == 0) ? 8'h22 : 8'h11, 32'd1000 + 3 * i);
    no_idle = 1'b0;
  endtask

  // Random combos over a small key set; mostly real sequences, some broken, some noise
  task automatic test_random_phase(input int n_items, input win_mode_e mode, input int step_max,
                                   input logic [TIME_W-1:0] t_start, input bit extreme_keys,
                                   input bit quiet);
    logic [KEY_W-1:0]  alphabet [4];
    keys_t             keys [COMBO_SLOTS];
    logic [LEN_W-1:0]  lens [COMBO_SLOTS];
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  key;
    int                sent;
    int                slot;
    int                run_len;
    int                cut;
    drain_results();
    for (int a = 0; a < 4; a++) alphabet[a] = KEY_W'($urandom_range(0, 255));
    if (extreme_keys) begin
      alphabet[0] = 8'h00;
      alphabet[1] = 8'hFF;
    end
    for (int k = 0; k < COMBO_SLOTS; k++) begin
      lens[k] = pick_len();
      for (int b = 0; b < KEY_BYTES; b++) keys[k][b] = alphabet[$urandom_range(0, 3)];
      program_slot(k, keys[k], lens[k], pick_window(mode));
    end
    no_idle = quiet;
    stamp = t_start;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        slot = $urandom_range(0, COMBO_SLOTS - 1);
        run_len = (lens[slot] == 0 || lens[slot] > MAX_COMBO_KEYS) ?
                  $urandom_range(1, MAX_COMBO_KEYS) : lens[slot];
        // now and then break the sequence off early
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, run_len) : run_len;
        for (int i = 0; i < cut; i++) begin
          stamp = stamp + next_step(step_max);
          send_press(keys[slot][i], stamp);
          sent++;
        end
      end else begin
        stamp = stamp + next_step(step_max);
        key = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 3)];
        send_press(key, stamp);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random idling, plus the long hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (recv_idle > 0) begin
      out_tready <= 1'b0;
      recv_idle = recv_idle - 1;
    end else begin
      out_tready <= 1'b1;
      recv_idle = pick_gap();
    end
  end

  // Compare each result word with the oldest owed mask
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_masks.size() == 0) begin
        $error("result word with no press pending: match_mask %h", out_tdata[MASK_W-1:0]);
        error_count++;
      end else begin
        exp_mask = pending_masks.pop_front();
        if (out_tdata[MASK_W-1:0] !== exp_mask) begin
          $error("match_mask mismatch: expected %h, actual %h", exp_mask,
                 out_tdata[MASK_W-1:0]);
          error_count++;
        end
        if (exp_mask != '0) matches_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results owed", cycle_count,
               pending_masks.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < COMBO_SLOTS; s++) begin
      combo_keys[s] = '0;
      combo_rule[s] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_short_history();
    test_window_edges();
    test_extreme_codes();
    test_bad_index();
    test_backpressure();
    test_random_phase(220, WIN_WIDE, 20, $urandom(), 1'b0, 1'b0);
    test_random_phase(210, WIN_TIGHT, 2, $urandom(), 1'b0, 1'b0);
    test_random_phase(210, WIN_MIXED, 60, 32'hFFFF_F000, 1'b0, 1'b1);
    test_random_phase(210, WIN_MIXED, 60, $urandom(), 1'b1, 1'b0);
    test_random_phase(210, WIN_MIXED, 100, $urandom(), 1'b0, 1'b0);
    test_random_phase(210, WIN_MIXED, 30, $urandom(), 1'b1, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    $display("summary: %0d presses over directed edge cases, a long receiver hold-off",
             presses_sent);
    $display("summary: and six random combo phases; %0d flagged a combo, %0d register writes",
             matches_seen, cfg_writes);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tksm_pkg.sv
rtl/core/tksm_front.sv
rtl/core/tksm_queue.sv
rtl/core/tksm_back.sv
rtl/core/timed_key_sequence_matcher.sv
sim/timed_key_sequence_matcher_tb.sv
